// ----- rtl/iirdf1_pkg.sv -----
// ----------------------------------------------------------------------------
// iirdf1_pkg
// Shared types, register map, operand codes and the microcode program of the
// direct form I IIR filter.
// ----------------------------------------------------------------------------
package iirdf1_pkg;

  localparam int TAPS_DEFAULT           = 4;
  localparam int SAMPLE_BITS_DEFAULT    = 16;
  localparam int COEF_FRAC_BITS_DEFAULT = 14;

  localparam int COEF_BITS  = 16;
  localparam int HIST_DEPTH = 3;
  localparam int NUM_REGS   = 7;
  localparam int ADDR_BITS  = 5;
  localparam int APB_DATA_BITS = 32;
  localparam int STEP_BITS  = 3;

  typedef logic signed [COEF_BITS-1:0] coef_t;

  localparam coef_t COEF_B0_RESET = 16'sd16384;

  // Register indexes.
  localparam logic [2:0] REG_B0 = 3'd0;
  localparam logic [2:0] REG_B1 = 3'd1;
  localparam logic [2:0] REG_B2 = 3'd2;
  localparam logic [2:0] REG_B3 = 3'd3;
  localparam logic [2:0] REG_A1 = 3'd4;
  localparam logic [2:0] REG_A2 = 3'd5;
  localparam logic [2:0] REG_A3 = 3'd6;

  // Multiplier data operand sources.
  localparam logic [2:0] SRC_X   = 3'd0;
  localparam logic [2:0] SRC_XH0 = 3'd1;
  localparam logic [2:0] SRC_XH1 = 3'd2;
  localparam logic [2:0] SRC_XH2 = 3'd3;
  localparam logic [2:0] SRC_YH0 = 3'd4;
  localparam logic [2:0] SRC_YH1 = 3'd5;
  localparam logic [2:0] SRC_YH2 = 3'd6;

  // One microcode word.
  typedef struct packed {
    logic [2:0] coef_sel;
    logic [2:0] data_sel;
    logic       sub;      // subtract the product instead of adding it
    logic       first;    // product replaces the accumulator
    logic       tap_end;  // last product of this tap
    logic [1:0] tap;
    logic       last;     // last word of the program
  } ucode_t;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    logic       mul_en;
    logic [2:0] coef_sel;
    logic [2:0] data_sel;
    logic       sub;
    logic       first;
    logic       round_en;
    logic       commit;
  } seq_ctl_t;

  function automatic ucode_t ucode_rom(input logic [STEP_BITS-1:0] addr);
    ucode_t w;
    case (addr)
      3'd0:    w = '{REG_B0, SRC_X,   1'b0, 1'b1, 1'b1, 2'd0, 1'b0};
      3'd1:    w = '{REG_B1, SRC_XH0, 1'b0, 1'b0, 1'b0, 2'd1, 1'b0};
      3'd2:    w = '{REG_A1, SRC_YH0, 1'b1, 1'b0, 1'b1, 2'd1, 1'b0};
      3'd3:    w = '{REG_B2, SRC_XH1, 1'b0, 1'b0, 1'b0, 2'd2, 1'b0};
      3'd4:    w = '{REG_A2, SRC_YH1, 1'b1, 1'b0, 1'b1, 2'd2, 1'b0};
      3'd5:    w = '{REG_B3, SRC_XH2, 1'b0, 1'b0, 1'b0, 2'd3, 1'b0};
      3'd6:    w = '{REG_A3, SRC_YH2, 1'b1, 1'b0, 1'b1, 2'd3, 1'b1};
      default: w = '{REG_B0, SRC_X,   1'b0, 1'b0, 1'b1, 2'd3, 1'b1};
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/iirdf1_regs.sv -----
// ----------------------------------------------------------------------------
// iirdf1_regs
// APB register file holding the seven Q2.14 filter coefficients.
// ----------------------------------------------------------------------------
module iirdf1_regs (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [iirdf1_pkg::ADDR_BITS-1:0]       paddr,
  input  logic [iirdf1_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic [iirdf1_pkg::APB_DATA_BITS-1:0]   prdata,
  output logic                                   pready,
  output iirdf1_pkg::coef_t                      coefs [iirdf1_pkg::NUM_REGS]
);

  logic [2:0] idx;
  logic       idx_ok;

  assign idx    = paddr[iirdf1_pkg::ADDR_BITS-1:2];
  assign idx_ok = idx < 3'(iirdf1_pkg::NUM_REGS);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < iirdf1_pkg::NUM_REGS; i++) begin
        coefs[i] <= (i == int'(iirdf1_pkg::REG_B0)) ? iirdf1_pkg::COEF_B0_RESET : '0;
      end
    end else if (psel && penable && pwrite && idx_ok) begin
      coefs[idx] <= pwdata[iirdf1_pkg::COEF_BITS-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (idx_ok) begin
      prdata = iirdf1_pkg::APB_DATA_BITS'($unsigned(coefs[idx]));
    end
  end

endmodule

// ----- rtl/iirdf1_seq.sv -----
// ----------------------------------------------------------------------------
// iirdf1_seq
// Microcode sequencer: steps through the product program, ends early when
// the tap count is reached, then drives drain, round and write-back.
// ----------------------------------------------------------------------------
module iirdf1_seq #(
  parameter int TAPS = iirdf1_pkg::TAPS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  out_free,
  output logic                  idle,
  output iirdf1_pkg::seq_ctl_t  ctl
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RUN   = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_ROUND = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]                       state, state_next;
  logic [iirdf1_pkg::STEP_BITS-1:0] step, step_next;
  iirdf1_pkg::ucode_t               word;
  logic                             prog_end;

  assign word = iirdf1_pkg::ucode_rom(step);

  // Leave the program after the last word, or after the last product of the
  // highest tap in use.
  assign prog_end = word.last ||
                    (word.tap_end && (({1'b0, word.tap} + 3'd1) >= 3'(TAPS)));

  always_comb begin
    state_next = state;
    step_next  = step;
    case (state)
      ST_IDLE: begin
        step_next = '0;
        if (start) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (prog_end) begin
          state_next = ST_DRAIN;
        end else begin
          step_next = step + 1'b1;
        end
      end
      ST_DRAIN: state_next = ST_ROUND;
      ST_ROUND: state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    ctl.mul_en   = (state == ST_RUN);
    ctl.coef_sel = word.coef_sel;
    ctl.data_sel = word.data_sel;
    ctl.sub      = word.sub;
    ctl.first    = word.first;
    ctl.round_en = (state == ST_ROUND);
    ctl.commit   = (state == ST_DONE) && out_free;
  end

  assign idle = (state == ST_IDLE);

endmodule

// ----- rtl/iirdf1_datapath.sv -----
// ----------------------------------------------------------------------------
// iirdf1_datapath
// Shared multiply-accumulate, sample histories, rounding and saturation, and
// the output register.
// ----------------------------------------------------------------------------
module iirdf1_datapath #(
  parameter int SAMPLE_BITS    = iirdf1_pkg::SAMPLE_BITS_DEFAULT,
  parameter int COEF_FRAC_BITS = iirdf1_pkg::COEF_FRAC_BITS_DEFAULT,
  localparam int DATA_W        = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  logic [DATA_W-1:0]     in_data,
  input  logic                  in_last,
  input  iirdf1_pkg::coef_t     coefs [iirdf1_pkg::NUM_REGS],
  input  iirdf1_pkg::seq_ctl_t  ctl,
  output logic                  out_free,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DATA_W-1:0]     out_data,
  output logic                  out_last
);

  localparam int PROD_BITS = iirdf1_pkg::COEF_BITS + SAMPLE_BITS;
  localparam int ACC_BITS  = PROD_BITS + 3;
  localparam logic signed [ACC_BITS-1:0] ROUND_HALF =
    ACC_BITS'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_BITS-1:0] SMAX =
    (ACC_BITS'(1) << (SAMPLE_BITS - 1)) - ACC_BITS'(1);
  localparam logic signed [ACC_BITS-1:0] SMIN = -SMAX - ACC_BITS'(1);

  logic signed [SAMPLE_BITS-1:0] x_reg;
  logic                          last_reg;
  logic signed [SAMPLE_BITS-1:0] xh [iirdf1_pkg::HIST_DEPTH];
  logic signed [SAMPLE_BITS-1:0] yh [iirdf1_pkg::HIST_DEPTH];
  logic signed [SAMPLE_BITS-1:0] opd;
  iirdf1_pkg::coef_t             coef_op;
  logic signed [PROD_BITS-1:0]   prod;
  logic                          prod_valid;
  logic                          prod_sub;
  logic                          prod_first;
  logic signed [ACC_BITS-1:0]    acc, acc_base, acc_next;
  logic signed [ACC_BITS-1:0]    rnd_sum, rnd_shift, rnd_sat;
  logic signed [SAMPLE_BITS-1:0] y_reg;

  always_comb begin
    case (ctl.data_sel)
      iirdf1_pkg::SRC_X:   opd = x_reg;
      iirdf1_pkg::SRC_XH0: opd = xh[0];
      iirdf1_pkg::SRC_XH1: opd = xh[1];
      iirdf1_pkg::SRC_XH2: opd = xh[2];
      iirdf1_pkg::SRC_YH0: opd = yh[0];
      iirdf1_pkg::SRC_YH1: opd = yh[1];
      iirdf1_pkg::SRC_YH2: opd = yh[2];
      default:             opd = '0;
    endcase
  end

  assign coef_op = (ctl.coef_sel < 3'(iirdf1_pkg::NUM_REGS)) ? coefs[ctl.coef_sel] : '0;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod       <= coef_op * opd;
      prod_sub   <= ctl.sub;
      prod_first <= ctl.first;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= ctl.mul_en;
    end
  end

  // Accumulation runs in the cycle after the multiply, from the registered product.
  always_comb begin
    acc_base = prod_first ? '0 : acc;
    acc_next = prod_sub ? acc_base - ACC_BITS'(prod) : acc_base + ACC_BITS'(prod);
  end

  always_ff @(posedge clk) begin
    if (prod_valid) begin
      acc <= acc_next;
    end
  end

  // Round half up, floor shift, then clamp to the sample range.
  always_comb begin
    rnd_sum   = acc + ROUND_HALF;
    rnd_shift = rnd_sum >>> COEF_FRAC_BITS;
    if (rnd_shift > SMAX) begin
      rnd_sat = SMAX;
    end else if (rnd_shift < SMIN) begin
      rnd_sat = SMIN;
    end else begin
      rnd_sat = rnd_shift;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      x_reg    <= in_data[SAMPLE_BITS-1:0];
      last_reg <= in_last;
    end
    if (ctl.round_en) begin
      y_reg <= rnd_sat[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < iirdf1_pkg::HIST_DEPTH; i++) begin
        xh[i] <= '0;
        yh[i] <= '0;
      end
    end else if (ctl.commit) begin
      for (int i = iirdf1_pkg::HIST_DEPTH - 1; i > 0; i--) begin
        xh[i] <= xh[i-1];
        yh[i] <= yh[i-1];
      end
      xh[0] <= x_reg;
      yh[0] <= y_reg;
    end
  end

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      out_data <= DATA_W'($unsigned(y_reg));
      out_last <= last_reg;
    end
  end

endmodule

// ----- rtl/iir_direct_form_one_filter.sv -----
// ----------------------------------------------------------------------------
// iir_direct_form_one_filter
// Direct form I IIR filter with a microcoded shared multiply-accumulate.
// ----------------------------------------------------------------------------
//  Channel   Direction  Signals                          Word contents
//  s_*       in         s_tvalid s_tready s_tdata s_tlast sample_in, block_end
//  m_*       out        m_tvalid m_tready m_tdata m_tlast sample_out, block_end_out
//  APB       in/out     psel penable pwrite paddr ...     coefficients b0..b3, a1..a3
//
// A new sample is accepted only while the sequencer is idle. Each sample runs
// 2*TAPS-1 product steps through the single multiplier, then drain, round and
// write-back, and returns to idle, where the next word is taken; write-back
// waits while the output register still holds an untaken word. Reset is
// synchronous and restores the coefficient defaults and clears both histories.
// ----------------------------------------------------------------------------
module iir_direct_form_one_filter #(
  parameter int TAPS           = iirdf1_pkg::TAPS_DEFAULT,
  parameter int SAMPLE_BITS    = iirdf1_pkg::SAMPLE_BITS_DEFAULT,
  parameter int COEF_FRAC_BITS = iirdf1_pkg::COEF_FRAC_BITS_DEFAULT,
  localparam int DATA_W        = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [DATA_W-1:0]                    s_tdata,   // sample_in
  input  logic                                 s_tlast,   // block_end
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [DATA_W-1:0]                    m_tdata,   // sample_out
  output logic                                 m_tlast,   // block_end_out
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [iirdf1_pkg::ADDR_BITS-1:0]     paddr,
  input  logic [iirdf1_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [iirdf1_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                                 pready
);

  iirdf1_pkg::coef_t    coefs [iirdf1_pkg::NUM_REGS];
  iirdf1_pkg::seq_ctl_t ctl;
  logic                 idle;
  logic                 out_free;
  logic                 load;

  assign s_tready = idle;
  assign load     = s_tvalid && idle;

  iirdf1_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coefs   (coefs)
  );

  iirdf1_seq #(
    .TAPS (TAPS)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (load),
    .out_free (out_free),
    .idle     (idle),
    .ctl      (ctl)
  );

  iirdf1_datapath #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .in_data   (s_tdata),
    .in_last   (s_tlast),
    .coefs     (coefs),
    .ctl       (ctl),
    .out_free  (out_free),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule
